/* hw/rtl/ac2k_pkg.sv */
// ac2k_pkg: shared types and constants for the edge interval bit decoder
// no dependencies; used by ac2k_front, ac2k_queue, ac2k_back and the top
`timescale 1ns / 1ps

package ac2k_pkg;

    // data bit capacity per capture
    localparam int MAX_DATA_BITS_DEFAULT = 128;

    // configuration register reset values
    localparam logic [15:0] GLITCH_LIMIT_RESET = 16'd64;
    localparam logic [15:0] TWO_THREE_RESET    = 16'd320;
    localparam logic [15:0] THREE_FOUR_RESET   = 16'd448;
    localparam logic [2:0]  START_BITS_RESET   = 3'd1;
    localparam logic [7:0]  BIT_LIMIT_RESET    = 8'd32;

    // configuration port shape and register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_GLITCH_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TWO_THREE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_THREE_FOUR   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_BITS   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_LIMIT    = 3'd4;

    // queue between classifier and decoder
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // classification of one edge item
    typedef enum logic [2:0] {
        KIND_HIGH   = 3'd0,
        KIND_GLITCH = 3'd1,
        KIND_TWO    = 3'd2,
        KIND_THREE  = 3'd3,
        KIND_FOUR   = 3'd4
    } edge_kind_t;

    typedef struct packed {
        logic       new_capture;
        edge_kind_t kind;
    } queue_entry_t;

    typedef struct packed {
        logic [QUEUE_CNT_W-1:0] count;
    } queue_status_t;

    typedef struct packed {
        logic pop;
        logic emit;
        logic at_limit;
    } back_status_t;

endpackage

/* hw/rtl/ac2k_in_if.sv */
// ac2k_in_if: input edge item channel, valid/ready with payload
// no dependencies
`timescale 1ns / 1ps

interface ac2k_in_if;
    logic        valid;
    logic        ready;
    logic        new_capture;
    logic        edge_level;
    logic [15:0] duration_us;

    modport source (output valid, output new_capture, output edge_level,
                    output duration_us, input ready);
    modport sink   (input valid, input new_capture, input edge_level,
                    input duration_us, output ready);
endinterface

/* hw/rtl/ac2k_out_if.sv */
// ac2k_out_if: decoded bit item channel, valid/ready with payload
// no dependencies
`timescale 1ns / 1ps

interface ac2k_out_if;
    logic       valid;
    logic       ready;
    logic       bit_value;
    logic [6:0] bit_index;
    logic       final_bit;

    modport source (output valid, output bit_value, output bit_index,
                    output final_bit, input ready);
    modport sink   (input valid, input bit_value, input bit_index,
                    input final_bit, output ready);
endinterface

/* hw/rtl/ac2k_front.sv */
// ac2k_front: accepts edge items and classifies them against the thresholds
// depends on ac2k_pkg and ac2k_in_if
`timescale 1ns / 1ps

module ac2k_front (
    ac2k_in_if.sink                item_in,
    input  logic [15:0]            glitch_limit_us,
    input  logic [15:0]            two_three_threshold_us,
    input  logic [15:0]            three_four_threshold_us,
    input  logic                   queue_full,
    output logic                   push,
    output ac2k_pkg::queue_entry_t push_entry
);

    ac2k_pkg::edge_kind_t kind;

    // take items whenever the queue has room
    assign item_in.ready = ~queue_full;
    assign push          = item_in.valid & ~queue_full;

    // period class: high level first, then glitch, then four-half before three-half compare
    always_comb
    begin
        if (item_in.edge_level)
        begin
            kind = ac2k_pkg::KIND_HIGH;
        end
        else if (item_in.duration_us < glitch_limit_us)
        begin
            kind = ac2k_pkg::KIND_GLITCH;
        end
        else if (item_in.duration_us >= three_four_threshold_us)
        begin
            kind = ac2k_pkg::KIND_FOUR;
        end
        else if (item_in.duration_us >= two_three_threshold_us)
        begin
            kind = ac2k_pkg::KIND_THREE;
        end
        else
        begin
            kind = ac2k_pkg::KIND_TWO;
        end
    end

    assign push_entry.new_capture = item_in.new_capture;
    assign push_entry.kind        = kind;

endmodule

/* hw/rtl/ac2k_queue.sv */
// ac2k_queue: short fifo of classified items between front and back
// depends on ac2k_pkg
`timescale 1ns / 1ps

module ac2k_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ac2k_pkg::queue_entry_t  push_entry,
    output logic                    full,
    input  logic                    pop,
    output logic                    head_valid,
    output ac2k_pkg::queue_entry_t  head_entry,
    output ac2k_pkg::queue_status_t status
);

    localparam int PW = ac2k_pkg::QUEUE_PTR_W;
    localparam int CW = ac2k_pkg::QUEUE_CNT_W;

    ac2k_pkg::queue_entry_t slot_reg [ac2k_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;

    assign full         = (count_reg == CW'(ac2k_pkg::QUEUE_DEPTH));
    assign head_valid   = (count_reg != '0);
    assign head_entry   = slot_reg[rd_ptr_reg];
    assign status.count = count_reg;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(ac2k_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(ac2k_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* hw/rtl/ac2k_back.sv */
// ac2k_back: bit decoder state, start bit stripping, bit limit and output register
// depends on ac2k_pkg and ac2k_out_if
`timescale 1ns / 1ps

module ac2k_back #(
    parameter int MAX_DATA_BITS = ac2k_pkg::MAX_DATA_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  ac2k_pkg::queue_entry_t head_entry,
    output logic                   pop,
    input  logic [2:0]             start_bits,
    input  logic [7:0]             bit_limit,
    ac2k_out_if.source             bit_out,
    output ac2k_pkg::back_status_t status
);

    localparam int BW = $clog2(MAX_DATA_BITS + 1);
    localparam int LW = (BW > 8) ? BW : 8;

    logic          prev_reg,    prev_next;
    logic          skip_reg,    skip_next;
    logic          startup_reg, startup_next;
    logic [2:0]    sbl_reg,     sbl_next;
    logic [BW-1:0] bd_reg,      bd_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_bit_reg;
    logic [6:0]    out_index_reg;
    logic          out_final_reg;

    logic [LW-1:0] lim;
    logic [LW-1:0] limit_ext;
    logic          emit;
    logic          have_bit;
    logic          dec_bit;
    logic          emit_final;
    logic [6:0]    emit_index;

    // effective limit, capped at the capacity
    assign limit_ext = LW'(bit_limit);
    assign lim       = (limit_ext > LW'(MAX_DATA_BITS)) ? LW'(MAX_DATA_BITS) : limit_ext;

    // take the next item when the output register is free or being drained
    assign pop = head_valid & (~out_valid_reg | bit_out.ready);

    // decode one classified item
    always_comb
    begin
        prev_next    = prev_reg;
        skip_next    = skip_reg;
        startup_next = startup_reg;
        sbl_next     = sbl_reg;
        bd_next      = bd_reg;
        have_bit     = 1'b0;
        dec_bit      = 1'b0;
        emit         = 1'b0;
        emit_final   = 1'b0;
        emit_index   = 7'(bd_reg);

        if (head_entry.new_capture)
        begin
            prev_next    = 1'b0;
            skip_next    = 1'b0;
            startup_next = 1'b1;
            sbl_next     = start_bits;
            bd_next      = '0;
        end

        if ((LW'(bd_next) < lim) && (head_entry.kind != ac2k_pkg::KIND_HIGH))
        begin
            if (startup_next)
            begin
                startup_next = 1'b0;
            end
            else
            begin
                case (head_entry.kind)
                    ac2k_pkg::KIND_FOUR:
                    begin
                        prev_next = 1'b0;
                        dec_bit   = 1'b0;
                        have_bit  = 1'b1;
                    end
                    ac2k_pkg::KIND_THREE:
                    begin
                        prev_next = ~prev_next;
                        dec_bit   = prev_next;
                        have_bit  = 1'b1;
                        skip_next = prev_next;
                    end
                    ac2k_pkg::KIND_TWO:
                    begin
                        dec_bit = 1'b1;
                        if (!skip_next)
                        begin
                            prev_next = 1'b1;
                            have_bit  = 1'b1;
                        end
                        skip_next = ~skip_next;
                    end
                    default:
                    begin
                        have_bit = 1'b0;
                    end
                endcase

                // strip start of frame bits, then emit
                if (have_bit)
                begin
                    if (sbl_next != 3'd0)
                    begin
                        sbl_next = sbl_next - 3'd1;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        emit_index = 7'(bd_next);
                        emit_final = ((LW'(bd_next) + LW'(1)) >= lim);
                        bd_next    = bd_next + BW'(1);
                    end
                end
            end
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= 1'b0;
            skip_reg    <= 1'b0;
            startup_reg <= 1'b1;
            sbl_reg     <= ac2k_pkg::START_BITS_RESET;
            bd_reg      <= '0;
        end
        else if (pop)
        begin
            prev_reg    <= prev_next;
            skip_reg    <= skip_next;
            startup_reg <= startup_next;
            sbl_reg     <= sbl_next;
            bd_reg      <= bd_next;
        end
    end

    // output register valid
    always_comb
    begin
        if (pop)
        begin
            out_valid_next = emit;
        end
        else if (bit_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_bit_reg   <= dec_bit;
            out_index_reg <= emit_index;
            out_final_reg <= emit_final;
        end
    end

    assign bit_out.valid     = out_valid_reg;
    assign bit_out.bit_value = out_bit_reg;
    assign bit_out.bit_index = out_index_reg;
    assign bit_out.final_bit = out_final_reg;

    assign status.pop      = pop;
    assign status.emit     = emit;
    assign status.at_limit = (LW'(bd_reg) >= lim);

endmodule

/* hw/rtl/ac2k_edge_interval_bit_decoder_top.sv */
// channel     dir  handshake      payload
// item_in     in   valid/ready    new_capture, edge_level, duration_us[15:0]
// bit_out     out  valid/ready    bit_value, bit_index[6:0], final_bit
// cfg         in   cfg_we only    cfg_index[2:0], cfg_data[15:0]
//
// one item per cycle sustained while the output is not stalled; a decoded bit is registered
// in a queue slot when its edge item is taken, then in the output register
// reset clears the queue, decoder state and configuration to defaults
// a stalled output holds the decoder; the front keeps taking items until the
// four-entry queue fills, then drops item_in.ready
//
// ac2k_edge_interval_bit_decoder_top: configuration registers and block assembly
// depends on ac2k_pkg, ac2k_in_if, ac2k_out_if, ac2k_front, ac2k_queue, ac2k_back
`timescale 1ns / 1ps

module ac2k_edge_interval_bit_decoder_top #(
    parameter int MAX_DATA_BITS = ac2k_pkg::MAX_DATA_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    ac2k_in_if.sink                             item_in,
    ac2k_out_if.source                          bit_out,
    input  logic                                cfg_we,
    input  logic [ac2k_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ac2k_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [15:0] glitch_limit_reg;
    logic [15:0] two_three_reg;
    logic [15:0] three_four_reg;
    logic [2:0]  start_bits_reg;
    logic [7:0]  bit_limit_reg;

    logic                    push;
    ac2k_pkg::queue_entry_t  push_entry;
    logic                    queue_full;
    logic                    pop;
    logic                    head_valid;
    ac2k_pkg::queue_entry_t  head_entry;
    ac2k_pkg::queue_status_t qstat;
    ac2k_pkg::back_status_t  bstat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glitch_limit_reg <= ac2k_pkg::GLITCH_LIMIT_RESET;
            two_three_reg    <= ac2k_pkg::TWO_THREE_RESET;
            three_four_reg   <= ac2k_pkg::THREE_FOUR_RESET;
            start_bits_reg   <= ac2k_pkg::START_BITS_RESET;
            bit_limit_reg    <= ac2k_pkg::BIT_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ac2k_pkg::CFG_GLITCH_LIMIT: glitch_limit_reg <= cfg_data;
                ac2k_pkg::CFG_TWO_THREE:    two_three_reg    <= cfg_data;
                ac2k_pkg::CFG_THREE_FOUR:   three_four_reg   <= cfg_data;
                ac2k_pkg::CFG_START_BITS:   start_bits_reg   <= cfg_data[2:0];
                ac2k_pkg::CFG_BIT_LIMIT:    bit_limit_reg    <= cfg_data[7:0];
                default:                    bit_limit_reg    <= bit_limit_reg;
            endcase
        end
    end

    // classifier
    ac2k_front u_front (
        .item_in                 (item_in),
        .glitch_limit_us         (glitch_limit_reg),
        .two_three_threshold_us  (two_three_reg),
        .three_four_threshold_us (three_four_reg),
        .queue_full              (queue_full),
        .push                    (push),
        .push_entry              (push_entry)
    );

    // classified item queue
    ac2k_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .status     (qstat)
    );

    // bit decoder and output register
    ac2k_back #(
        .MAX_DATA_BITS (MAX_DATA_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .start_bits (start_bits_reg),
        .bit_limit  (bit_limit_reg),
        .bit_out    (bit_out),
        .status     (bstat)
    );

    // a new output item only follows a decoded queue entry
    a_valid_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(bit_out.valid) |-> $past(bstat.pop) && $past(bstat.emit))
        else $error("output valid rose without a decoded item");

    // queue fill never passes its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.count <= ac2k_pkg::QUEUE_CNT_W'(ac2k_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // a waiting final bit means the decoder sits at its limit
    a_final_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_out.valid && bit_out.final_bit) |-> bstat.at_limit)
        else $error("final bit shown while decoder below its limit");

endmodule

/* test/tb_ac2k_edge_interval_bit_decoder_top.sv */
// tb_ac2k_edge_interval_bit_decoder_top: self-checking bench for the edge interval bit decoder
// predicts every decoded bit from edge items, checks each output item in order
// depends on ac2k_pkg, ac2k_in_if, ac2k_out_if, ac2k_edge_interval_bit_decoder_top
`timescale 1ns / 1ps

module tb_ac2k_edge_interval_bit_decoder_top;
    import ac2k_pkg::*;

    localparam int MAX_DATA_BITS = MAX_DATA_BITS_DEFAULT;
    localparam int IDLE_PCT      = 20;
    localparam int HOLD_AT       = 700;
    localparam int HOLD_CYCLES   = 300;
    localparam int CALM_FROM     = 1200;
    localparam int CALM_TO       = 1500;
    localparam int DRAIN_CYCLES  = 24;
    localparam int STALL_LIMIT   = 2000;
    localparam int SHOW_LIMIT    = 10;

    typedef struct packed {
        logic        new_capture;
        logic        edge_level;
        logic [15:0] duration_us;
    } edge_item_t;

    typedef struct packed {
        logic       bit_value;
        logic [6:0] bit_index;
        logic       final_bit;
    } decoded_bit_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ac2k_in_if  edge_if ();
    ac2k_out_if bit_if ();

    ac2k_edge_interval_bit_decoder_top #(
        .MAX_DATA_BITS (MAX_DATA_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (edge_if),
        .bit_out   (bit_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies
    logic [15:0] cfg_glitch;
    logic [15:0] cfg_two_three;
    logic [15:0] cfg_three_four;
    logic [2:0]  cfg_start;
    logic [7:0]  cfg_limit;

    // decoder state copies
    logic        prev_bit;
    logic        skip;
    logic        startup;
    logic [2:0]  start_left;
    int          decoded_count;

    edge_item_t   pending_edges[$];
    decoded_bit_t expected_bits[$];
    edge_item_t   next_edge;
    decoded_bit_t seen_bit;
    decoded_bit_t want_bit;

    int  edges_pushed;
    int  edges_accepted;
    int  bits_checked;
    int  mismatch_count;
    int  phase_count;
    int  quiet_cycles;
    int  hold_left;
    bit  hold_done;
    bit  edge_taken;
    bit  bit_taken;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bit steady_window();
        return edges_accepted >= CALM_FROM && edges_accepted < CALM_TO;
    endfunction

    // capture start or reset: clear the decoder copy
    task automatic clear_capture();
        prev_bit      = 1'b0;
        skip          = 1'b0;
        startup       = 1'b1;
        start_left    = cfg_start;
        decoded_count = 0;
    endtask

    task automatic store_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
        case (idx)
            CFG_GLITCH_LIMIT: cfg_glitch     = data;
            CFG_TWO_THREE:    cfg_two_three  = data;
            CFG_THREE_FOUR:   cfg_three_four = data;
            CFG_START_BITS:   cfg_start      = data[2:0];
            CFG_BIT_LIMIT:    cfg_limit      = data[7:0];
            default:          ;
        endcase
    endtask

    // one edge item in, at most one decoded bit out
    task automatic decode_edge(input edge_item_t e);
        int           lim;
        edge_kind_t   kind;
        logic         val;
        logic         have;
        decoded_bit_t res;
        if (e.new_capture)
            clear_capture();
        lim = (cfg_limit > MAX_DATA_BITS) ? MAX_DATA_BITS : int'(cfg_limit);
        if (decoded_count >= lim)
            return;
        if (e.edge_level)
            return;
        if (startup)
        begin
            startup = 1'b0;
            return;
        end
        if (e.duration_us < cfg_glitch)
            return;
        if (e.duration_us >= cfg_three_four)
            kind = KIND_FOUR;
        else if (e.duration_us >= cfg_two_three)
            kind = KIND_THREE;
        else
            kind = KIND_TWO;
        have = 1'b1;
        case (kind)
            KIND_FOUR:
            begin
                prev_bit = 1'b0;
                val      = 1'b0;
            end
            KIND_THREE:
            begin
                prev_bit = ~prev_bit;
                val      = prev_bit;
                skip     = prev_bit;
            end
            default:
            begin
                val  = 1'b1;
                have = ~skip;
                if (!skip)
                    prev_bit = 1'b1;
                skip = ~skip;
            end
        endcase
        if (!have)
            return;
        // start of frame bits are swallowed
        if (start_left != 3'd0)
        begin
            start_left = start_left - 3'd1;
            return;
        end
        res.bit_value = val;
        res.bit_index = decoded_count[6:0];
        res.final_bit = (decoded_count + 1 >= lim);
        expected_bits.push_back(res);
        decoded_count++;
    endtask

    task automatic note_mismatch(input string what, input decoded_bit_t want,
                                 input decoded_bit_t got);
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
            $display("%s: expected value=%0d index=%0d final=%0d, got value=%0d index=%0d final=%0d",
                     what, want.bit_value, want.bit_index, want.final_bit,
                     got.bit_value, got.bit_index, got.final_bit);
    endtask

    // stimulus helpers
    task automatic push_edge(input logic nc, input logic lvl, input logic [15:0] dur);
        pending_edges.push_back({nc, lvl, dur});
        edges_pushed++;
    endtask

    function automatic edge_kind_t pick_kind();
        int r;
        r = $urandom_range(99, 0);
        if (r < 45)
            return KIND_TWO;
        if (r < 75)
            return KIND_THREE;
        if (r < 95)
            return KIND_FOUR;
        return KIND_GLITCH;
    endfunction

    // a period that falls in the given class under the current thresholds, random if none can
    function automatic logic [15:0] period_for(input edge_kind_t kind);
        int lo;
        int hi;
        int pick;
        case (kind)
            KIND_FOUR:
            begin
                lo = cfg_three_four;
                hi = ($urandom_range(15, 0) == 0) ? 65535 : lo + 160;
                if (hi > 65535)
                    hi = 65535;
            end
            KIND_THREE:
            begin
                lo = (cfg_two_three > cfg_glitch) ? cfg_two_three : cfg_glitch;
                hi = int'(cfg_three_four) - 1;
            end
            KIND_TWO:
            begin
                lo = cfg_glitch;
                hi = (cfg_two_three < cfg_three_four) ? cfg_two_three : cfg_three_four;
                hi = hi - 1;
            end
            KIND_GLITCH:
            begin
                lo = 0;
                hi = int'(cfg_glitch) - 1;
            end
            default:
            begin
                lo = 0;
                hi = 65535;
            end
        endcase
        if (lo > hi)
            return 16'($urandom_range(65535, 0));
        pick = $urandom_range(7, 0);
        if (pick == 0)
            return 16'(lo);
        if (pick == 1)
            return 16'(hi);
        return 16'($urandom_range(hi, lo));
    endfunction

    // well-formed capture: start edge, then periods with optional high pulses
    // the number of periods is capped by the room left in the phase's edge budget
    task automatic queue_capture(input int room);
        int eff;
        int periods;
        eff = (cfg_limit > MAX_DATA_BITS) ? MAX_DATA_BITS : int'(cfg_limit);
        periods = $urandom_range((eff + cfg_start) * 2 + 8, 2);
        if (periods > (room + 1) / 2)
            periods = (room + 1) / 2;
        push_edge(1'b1, $urandom_range(3, 0) == 0, period_for(pick_kind()));
        for (int i = 0; i < periods; i++)
        begin
            if ($urandom_range(9, 0) < 7)
                push_edge(1'b0, 1'b1, 16'($urandom_range(65535, 0)));
            push_edge(1'b0, 1'b0, period_for(pick_kind()));
        end
    endtask

    // random edges, stray capture starts included
    task automatic queue_noise();
        int n;
        n = $urandom_range(12, 1);
        for (int i = 0; i < n; i++)
            push_edge($urandom_range(7, 0) == 0, $urandom_range(1, 0),
                      16'($urandom_range(65535, 0)));
    endtask

    // queue about budget edge items
    task automatic fill_phase(input int budget);
        int base;
        base = edges_pushed;
        while (edges_pushed - base < budget)
        begin
            if ($urandom_range(99, 0) < 85)
                queue_capture(budget - (edges_pushed - base));
            else
                queue_noise();
        end
    endtask

    // all items taken, all bits seen, then let the queue drain
    task automatic wait_idle();
        while (edges_pushed != edges_accepted || expected_bits.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // called at a falling edge; caller lowers cfg_we after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        store_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [15:0] g, input logic [15:0] t23,
                             input logic [15:0] t34, input logic [2:0] sb,
                             input logic [7:0] lim, input int budget);
        logic [15:0] data;
        wait_idle();
        // spare indexes must not touch anything
        for (int i = CFG_BIT_LIMIT + 1; i < (1 << CFG_INDEX_W); i++)
            write_reg(CFG_INDEX_W'(i), 16'($urandom_range(65535, 0)));
        write_reg(CFG_GLITCH_LIMIT, g);
        write_reg(CFG_TWO_THREE, t23);
        write_reg(CFG_THREE_FOUR, t34);
        data = 16'($urandom_range(65535, 0));
        data[2:0] = sb;
        write_reg(CFG_START_BITS, data);
        data = 16'($urandom_range(65535, 0));
        data[7:0] = lim;
        write_reg(CFG_BIT_LIMIT, data);
        cfg_we <= 1'b0;
        phase_count++;
        fill_phase(budget);
    endtask

    // edge item driver
    always @(negedge clk)
    begin
        if (!rst_n)
            edge_if.valid <= 1'b0;
        else if (!edge_if.valid || edge_taken)
        begin
            if (pending_edges.size() != 0 &&
                (steady_window() || $urandom_range(99, 0) >= IDLE_PCT))
            begin
                next_edge = pending_edges.pop_front();
                edge_if.valid       <= 1'b1;
                edge_if.new_capture <= next_edge.new_capture;
                edge_if.edge_level  <= next_edge.edge_level;
                edge_if.duration_us <= next_edge.duration_us;
            end
            else
                edge_if.valid <= 1'b0;
        end
    end

    // output ready, with one long hold-off while edges keep coming
    always @(negedge clk)
    begin
        if (!rst_n)
            bit_if.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            bit_if.ready <= 1'b0;
        end
        else if (!hold_done && edges_accepted >= HOLD_AT && pending_edges.size() > 20)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            bit_if.ready <= 1'b0;
        end
        else
            bit_if.ready <= steady_window() || $urandom_range(99, 0) >= IDLE_PCT;
    end

    // sample both channels: check output first, then predict from the input
    always @(posedge clk)
    begin
        edge_taken = 1'b0;
        bit_taken  = 1'b0;
        if (rst_n)
        begin
            if (bit_if.valid && bit_if.ready)
            begin
                bit_taken = 1'b1;
                bits_checked++;
                seen_bit = {bit_if.bit_value, bit_if.bit_index, bit_if.final_bit};
                if (expected_bits.size() == 0)
                    note_mismatch("unexpected bit", '0, seen_bit);
                else
                begin
                    want_bit = expected_bits.pop_front();
                    if (seen_bit.bit_value !== want_bit.bit_value ||
                        seen_bit.bit_index !== want_bit.bit_index ||
                        seen_bit.final_bit !== want_bit.final_bit)
                        note_mismatch("bit mismatch", want_bit, seen_bit);
                end
            end
            if (edge_if.valid && edge_if.ready)
            begin
                edge_taken = 1'b1;
                edges_accepted++;
                decode_edge({edge_if.new_capture, edge_if.edge_level, edge_if.duration_us});
            end
        end
    end

    // watchdog on lack of progress
    always @(negedge clk)
    begin
        if (edge_taken || bit_taken)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // reset, directed edges, then phases of register settings
    initial
    begin
        logic [15:0] t23;
        logic [15:0] t34;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        edge_if.valid       = 1'b0;
        edge_if.new_capture = 1'b0;
        edge_if.edge_level  = 1'b0;
        edge_if.duration_us = '0;
        bit_if.ready        = 1'b0;
        cfg_glitch          = GLITCH_LIMIT_RESET;
        cfg_two_three       = TWO_THREE_RESET;
        cfg_three_four      = THREE_FOUR_RESET;
        cfg_start           = START_BITS_RESET;
        cfg_limit           = BIT_LIMIT_RESET;
        clear_capture();
        phase_count         = 1;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed edges under reset settings
        push_edge(1'b1, 1'b1, 16'hFFFF);  // high pulse first, startup still pending
        push_edge(1'b0, 1'b0, 16'd500);   // first period of capture dropped
        push_edge(1'b0, 1'b0, 16'd0);     // glitch
        push_edge(1'b0, 1'b0, 16'd63);    // glitch just under limit
        push_edge(1'b0, 1'b0, 16'd64);    // two halves, eaten as start bit
        push_edge(1'b0, 1'b0, 16'd100);   // two halves, skipped
        push_edge(1'b0, 1'b1, 16'd0);     // high pulse ignored
        push_edge(1'b0, 1'b0, 16'd319);   // two halves, first data bit
        push_edge(1'b0, 1'b0, 16'd319);   // skipped
        push_edge(1'b0, 1'b0, 16'd320);   // three halves at the threshold
        push_edge(1'b0, 1'b0, 16'd447);   // three halves just under four
        push_edge(1'b0, 1'b0, 16'd448);   // four halves at the threshold
        push_edge(1'b0, 1'b0, 16'hFFFF);  // saturated duration
        push_edge(1'b0, 1'b0, 16'd200);   // two halves after three sets skip
        push_edge(1'b0, 1'b0, 16'd200);
        push_edge(1'b1, 1'b0, 16'd400);   // new capture mid stream
        push_edge(1'b0, 1'b0, 16'h8000);
        push_edge(1'b0, 1'b0, 16'h5555);
        push_edge(1'b0, 1'b0, 16'hAAAA);
        push_edge(1'b0, 1'b1, 16'hFFFF);
        push_edge(1'b1, 1'b1, 16'h0000);  // new capture on a high pulse
        push_edge(1'b0, 1'b0, 16'd400);
        push_edge(1'b0, 1'b0, 16'd330);
        fill_phase(230);

        run_phase(16'd40, 16'd250, 16'd380, 3'd0, 8'd16, 200);
        // lowest thresholds, top four-half threshold
        run_phase(16'd0, 16'd1, 16'hFFFF, 3'd0, 8'd128, 260);
        // everything at the top: only saturated periods decode
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 8'd255, 80);
        // thresholds out of order, limit of one bit
        run_phase(16'd50, 16'd600, 16'd300, 3'd2, 8'd1, 120);
        // zero limit never emits
        run_phase(16'd64, 16'd320, 16'd448, 3'd3, 8'd0, 60);
        // limit above capacity clamps, indexes run up to the top
        run_phase(16'd30, 16'd200, 16'd300, 3'd4, 8'd200, 420);
        repeat (2)
        begin
            t23 = 16'($urandom_range(400, 150));
            t34 = t23 + 16'($urandom_range(250, 30));
            run_phase(16'($urandom_range(120, 10)), t23, t34,
                      3'($urandom_range(7, 0)), 8'($urandom_range(40, 1)), 180);
        end

        wait_idle();
        while (expected_bits.size() != 0)
            note_mismatch("missing bit", expected_bits.pop_front(), '0);

        $display("covered %0d edge items and %0d decoded bits over %0d register settings",
                 edges_accepted, bits_checked, phase_count);
        $display("output held off for %0d cycles mid-run, bit limits from zero to above capacity",
                 HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/ac2k_pkg.sv
hw/rtl/ac2k_in_if.sv
hw/rtl/ac2k_out_if.sv
hw/rtl/ac2k_front.sv
hw/rtl/ac2k_queue.sv
hw/rtl/ac2k_back.sv
hw/rtl/ac2k_edge_interval_bit_decoder_top.sv
test/tb_ac2k_edge_interval_bit_decoder_top.sv
